FILE: hw/rtl/lgts_pkg.sv
package lgts_pkg;

  // Sizing of the count tables.
  localparam int TOPICS     = 64;
  localparam int DOCS       = 1024;
  localparam int VOCAB      = 4096;
  localparam int COUNT_BITS = 16;
  localparam int TOTAL_BITS = 24;

  // Port field widths.
  localparam int DOC_FIELD_W  = 10;
  localparam int WORD_FIELD_W = 12;
  localparam int TOPIC_FIELD_W = 6;
  localparam int DRAW_W       = 17;
  localparam int PRIOR_W      = 24;
  localparam int VOCAB_REG_W  = 13;
  localparam int NUMT_W       = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 24;

  // Derived address widths.
  localparam int TOPIC_W = $clog2(TOPICS);
  localparam int K_W     = $clog2(TOPICS + 1);
  localparam int KN_W    = (K_W > NUMT_W) ? K_W : NUMT_W;
  localparam int DOC_W   = $clog2(DOCS);
  localparam int WORD_W  = $clog2(VOCAB);
  localparam int DT_AW   = DOC_W + TOPIC_W;
  localparam int WT_AW   = WORD_W + TOPIC_W;
  localparam int DT_DEPTH = DOCS * TOPICS;
  localparam int WT_DEPTH = VOCAB * TOPICS;
  localparam int CLR_DEPTH = (DT_DEPTH > WT_DEPTH) ? DT_DEPTH : WT_DEPTH;
  localparam int CLR_W    = $clog2(CLR_DEPTH);

  // Fixed-point datapath widths.
  localparam int FRAC   = 16;
  localparam int FA_W   = COUNT_BITS + FRAC + 1;
  localparam int FB_LO  = (FA_W + 1) / 2;
  localparam int FB_HI  = FA_W - FB_LO;
  localparam int PROD_W = 2 * FA_W;
  localparam int VB_W   = VOCAB_REG_W + PRIOR_W;
  localparam int DEN_W  = TOTAL_BITS + FRAC + 1;
  localparam int REM_W  = DEN_W + 1;
  localparam int WGT_W  = 32;
  localparam int HI_W   = PROD_W - WGT_W;
  localparam int CMP_W  = (HI_W > REM_W) ? HI_W : REM_W;
  localparam int DIV_STEP    = 4;
  localparam int DIV_CYCLES  = WGT_W / DIV_STEP;
  localparam int DIVCNT_W    = $clog2(DIV_CYCLES);
  localparam int SUM_W  = WGT_W + TOPIC_W;
  localparam int SCALE_W = 17;
  localparam int WC_W   = WGT_W + SCALE_W;
  localparam int THR_W  = DRAW_W + SUM_W;
  localparam logic [SCALE_W-1:0] DRAW_SCALE = SCALE_W'(100000);

  // Register reset values.
  localparam logic [PRIOR_W-1:0]     ALPHA_RST = PRIOR_W'(6554);
  localparam logic [PRIOR_W-1:0]     BETA_RST  = PRIOR_W'(655);
  localparam logic [VOCAB_REG_W-1:0] VOCAB_RST = VOCAB_REG_W'(4096);
  localparam logic [NUMT_W-1:0]      NUMT_RST  = NUMT_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 2'd0,
    CFG_BETA  = 2'd1,
    CFG_VOCAB = 2'd2,
    CFG_NUMT  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_ADD      = 1'b0,
    OP_RESAMPLE = 1'b1
  } op_e;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_RDT, ST_CHK,
    ST_WRD, ST_WLD, ST_WMA, ST_WMB, ST_WDS, ST_WDW,
    ST_THR, ST_PRD, ST_PMUL, ST_PACC,
    ST_URD, ST_UWR, ST_EMIT
  } state_e;

  function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] v);
    cnt_inc = (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic logic [TOTAL_BITS-1:0] tot_inc(input logic [TOTAL_BITS-1:0] v);
    tot_inc = (&v) ? v : v + TOTAL_BITS'(1);
  endfunction

endpackage

FILE: hw/rtl/lgts_if.sv
interface lgts_tok_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 operation;
  logic [lgts_pkg::DOC_FIELD_W-1:0]     doc_index;
  logic [lgts_pkg::WORD_FIELD_W-1:0]    word_index;
  logic [lgts_pkg::TOPIC_FIELD_W-1:0]   old_topic;
  logic [lgts_pkg::DRAW_W-1:0]          random_draw;

  modport source (output valid, operation, doc_index, word_index, old_topic, random_draw,
                  input ready);
  modport sink (input valid, operation, doc_index, word_index, old_topic, random_draw,
                output ready);
endinterface

interface lgts_res_if;
  logic                               valid;
  logic                               ready;
  logic [lgts_pkg::TOPIC_FIELD_W-1:0] new_topic;
  logic                               count_error;

  modport source (output valid, new_topic, count_error, input ready);
  modport sink (input valid, new_topic, count_error, output ready);
endinterface

interface lgts_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lgts_pkg::CFG_IDX_W-1:0]  index;
  logic [lgts_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/lgts_ram.sv
module lgts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/lgts_div.sv
module lgts_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [lgts_pkg::PROD_W-1:0]       num_i,
  input  logic [lgts_pkg::DEN_W-1:0]        den_i,
  output logic                              done_o,
  output logic [lgts_pkg::WGT_W-1:0]        quo_o
);

  localparam int REM_W = lgts_pkg::REM_W;
  localparam int WGT_W = lgts_pkg::WGT_W;

  logic                             busy_q;
  logic                             done_q;
  logic [lgts_pkg::DIVCNT_W-1:0]    cnt_q;
  logic [lgts_pkg::DEN_W-1:0]       den_q;
  logic [REM_W-1:0]                 rem_q, rem_d;
  logic [WGT_W-1:0]                 low_q, low_d;
  logic [WGT_W-1:0]                 quo_q, quo_d;
  logic [lgts_pkg::CMP_W-1:0]       hi_ext, den_ext;
  logic                             saturate;

  // A quotient of 2^32 or more shows in the high part of the numerator alone.
  assign hi_ext   = lgts_pkg::CMP_W'(num_i[lgts_pkg::PROD_W-1:WGT_W]);
  assign den_ext  = lgts_pkg::CMP_W'(den_i);
  assign saturate = (hi_ext >= den_ext);

  // Four restoring division steps per cycle.
  always_comb begin
    rem_d = rem_q;
    low_d = low_q;
    quo_d = quo_q;
    for (int j = 0; j < lgts_pkg::DIV_STEP; j++) begin
      rem_d = {rem_d[REM_W-2:0], low_d[WGT_W-1]};
      low_d = {low_d[WGT_W-2:0], 1'b0};
      quo_d = {quo_d[WGT_W-2:0], 1'b0};
      if (rem_d >= REM_W'(den_q)) begin
        rem_d    = rem_d - REM_W'(den_q);
        quo_d[0] = 1'b1;
      end
    end
  end

  // Sequencing of the division.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (den_i == '0 || saturate) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + lgts_pkg::DIVCNT_W'(1);
        if (cnt_q == lgts_pkg::DIVCNT_W'(lgts_pkg::DIV_CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= REM_W'(num_i[lgts_pkg::PROD_W-1:WGT_W]);
      low_q <= num_i[WGT_W-1:0];
      if (den_i == '0) begin
        quo_q <= '0;
      end else if (saturate) begin
        quo_q <= '1;
      end else begin
        quo_q <= '0;
      end
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= low_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: hw/rtl/lda_gibbs_topic_sampler.sv
// Collapsed Gibbs topic sampler.
// Token items arrive on tok_i (valid/ready); one result per item leaves on
// res_o (new_topic, count_error). Registers are written on cfg_i, which is
// always ready; write them only while the block is idle.
// After reset the block clears its count memories, one entry per cycle up to
// 262144 entries (the word-topic table depth); tok_i stays not ready meanwhile.
// Items are handled one at a time. An add reads the three count memories,
// writes them back incremented and then emits its result. A resample
// handles the K topics in use in turn: each topic needs a read of the three
// count memories, a product formed in two halves and a divider that
// delivers four quotient bits per cycle (it skips its steps when the
// divisor is zero or the quotient saturates), then a second pass over the
// stored weights with one constant multiply and compare per topic that
// stops at the chosen topic.
// The result waits in an output register; tok_i is ready again as soon as
// that register is loaded, so the next item runs while the receiver stalls.
// A finished item waits for the output register only if it is still full.
module lda_gibbs_topic_sampler (
  input  logic       clk_i,
  input  logic       rst_ni,
  lgts_tok_if.sink   tok_i,
  lgts_res_if.source res_o,
  lgts_cfg_if.sink   cfg_i
);

  localparam int TOPIC_W    = lgts_pkg::TOPIC_W;
  localparam int COUNT_BITS = lgts_pkg::COUNT_BITS;
  localparam int TOTAL_BITS = lgts_pkg::TOTAL_BITS;

  lgts_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [lgts_pkg::PRIOR_W-1:0]     alpha_q, beta_q;
  logic [lgts_pkg::VOCAB_REG_W-1:0] vocab_q;
  logic [lgts_pkg::NUMT_W-1:0]      numt_q;

  // Item and datapath registers.
  logic                             op_q;
  logic [lgts_pkg::DOC_W-1:0]       doc_q;
  logic [lgts_pkg::WORD_W-1:0]      word_q;
  logic [TOPIC_W-1:0]               t_q, idx_q;
  logic [lgts_pkg::DRAW_W-1:0]      draw_q;
  logic [lgts_pkg::K_W-1:0]         k_q;
  logic                             err_q;
  logic [lgts_pkg::VB_W-1:0]        vb_q;
  logic [lgts_pkg::FA_W-1:0]        fa_q, fb_q;
  logic [lgts_pkg::DEN_W-1:0]       den_q;
  logic [lgts_pkg::PROD_W-1:0]      prod_q;
  logic [lgts_pkg::SUM_W-1:0]       sum_q;
  logic [lgts_pkg::THR_W-1:0]       thr_q, runc_q, runc_sum;
  logic [lgts_pkg::WC_W-1:0]        wc_q;
  logic [lgts_pkg::CLR_W-1:0]       clr_q;

  // Result register.
  logic                               res_valid_q;
  logic [lgts_pkg::TOPIC_FIELD_W-1:0] res_topic_q;
  logic                               res_err_q;

  // Memory ports.
  logic                             cnt_we, w_we;
  logic [TOPIC_W-1:0]               mem_topic;
  logic [lgts_pkg::DT_AW-1:0]       dt_addr;
  logic [lgts_pkg::WT_AW-1:0]       wt_addr;
  logic [TOPIC_W-1:0]               tot_addr;
  logic [COUNT_BITS-1:0]            dt_wdata, wt_wdata, dt_rdata, wt_rdata;
  logic [TOTAL_BITS-1:0]            tot_wdata, tot_rdata;
  logic [lgts_pkg::WGT_W-1:0]       w_rdata;

  // Divider.
  logic                             div_start, div_done;
  logic [lgts_pkg::WGT_W-1:0]       div_quo;

  // Decode helpers.
  logic                             tok_xfer, emit_ok, cnt_zero, last_topic, hit;
  logic [lgts_pkg::KN_W-1:0]        num_ext, k_ext, t_ext;
  logic [lgts_pkg::VOCAB_REG_W-1:0] v_eff;

  assign tok_xfer   = tok_i.valid && tok_i.ready;
  assign emit_ok    = !res_valid_q || res_o.ready;
  assign cnt_zero   = (dt_rdata == '0) || (wt_rdata == '0) || (tot_rdata == '0);
  assign last_topic = (idx_q == TOPIC_W'(k_q - lgts_pkg::K_W'(1)));
  assign runc_sum   = runc_q + lgts_pkg::THR_W'(wc_q);
  // The running sum exceeds draw*sum/100000 exactly when run*100000 > draw*sum.
  assign hit        = (thr_q < runc_sum);
  assign v_eff      = (vocab_q == '0) ? lgts_pkg::VOCAB_REG_W'(1) : vocab_q;

  // Clamp the topic count and the incoming topic.
  always_comb begin
    num_ext = lgts_pkg::KN_W'(numt_q);
    if (num_ext < lgts_pkg::KN_W'(2)) begin
      k_ext = lgts_pkg::KN_W'(2);
    end else if (num_ext > lgts_pkg::KN_W'(lgts_pkg::TOPICS)) begin
      k_ext = lgts_pkg::KN_W'(lgts_pkg::TOPICS);
    end else begin
      k_ext = num_ext;
    end
    t_ext = lgts_pkg::KN_W'(tok_i.old_topic);
    if (t_ext >= k_ext) begin
      t_ext = k_ext - lgts_pkg::KN_W'(1);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lgts_pkg::ST_CLEAR: if (clr_q == lgts_pkg::CLR_W'(lgts_pkg::CLR_DEPTH - 1)) begin
        state_d = lgts_pkg::ST_IDLE;
      end
      lgts_pkg::ST_IDLE: if (tok_i.valid) begin
        state_d = lgts_pkg::ST_RDT;
      end
      lgts_pkg::ST_RDT: state_d = lgts_pkg::ST_CHK;
      lgts_pkg::ST_CHK: begin
        if (op_q == lgts_pkg::OP_ADD || cnt_zero) begin
          state_d = lgts_pkg::ST_EMIT;
        end else begin
          state_d = lgts_pkg::ST_WRD;
        end
      end
      lgts_pkg::ST_WRD: state_d = lgts_pkg::ST_WLD;
      lgts_pkg::ST_WLD: state_d = lgts_pkg::ST_WMA;
      lgts_pkg::ST_WMA: state_d = lgts_pkg::ST_WMB;
      lgts_pkg::ST_WMB: state_d = lgts_pkg::ST_WDS;
      lgts_pkg::ST_WDS: state_d = lgts_pkg::ST_WDW;
      lgts_pkg::ST_WDW: if (div_done) begin
        state_d = last_topic ? lgts_pkg::ST_THR : lgts_pkg::ST_WRD;
      end
      lgts_pkg::ST_THR:  state_d = lgts_pkg::ST_PRD;
      lgts_pkg::ST_PRD:  state_d = lgts_pkg::ST_PMUL;
      lgts_pkg::ST_PMUL: state_d = lgts_pkg::ST_PACC;
      lgts_pkg::ST_PACC: begin
        state_d = (hit || last_topic) ? lgts_pkg::ST_URD : lgts_pkg::ST_PRD;
      end
      lgts_pkg::ST_URD: state_d = lgts_pkg::ST_UWR;
      lgts_pkg::ST_UWR: state_d = lgts_pkg::ST_EMIT;
      lgts_pkg::ST_EMIT: if (emit_ok) begin
        state_d = lgts_pkg::ST_IDLE;
      end
      default: state_d = lgts_pkg::ST_IDLE;
    endcase
  end

  // Memory controls and divider start.
  always_comb begin
    cnt_we    = 1'b0;
    w_we      = 1'b0;
    div_start = 1'b0;
    dt_wdata  = lgts_pkg::cnt_inc(dt_rdata);
    wt_wdata  = lgts_pkg::cnt_inc(wt_rdata);
    tot_wdata = lgts_pkg::tot_inc(tot_rdata);
    case (state_q)
      lgts_pkg::ST_CLEAR: begin
        cnt_we    = 1'b1;
        dt_wdata  = '0;
        wt_wdata  = '0;
        tot_wdata = '0;
      end
      lgts_pkg::ST_CHK: begin
        if (op_q == lgts_pkg::OP_ADD) begin
          cnt_we = 1'b1;
        end else if (!cnt_zero) begin
          cnt_we    = 1'b1;
          dt_wdata  = dt_rdata - COUNT_BITS'(1);
          wt_wdata  = wt_rdata - COUNT_BITS'(1);
          tot_wdata = tot_rdata - TOTAL_BITS'(1);
        end
      end
      lgts_pkg::ST_WDS: div_start = 1'b1;
      lgts_pkg::ST_WDW: w_we = div_done;
      lgts_pkg::ST_UWR: cnt_we = 1'b1;
      default: ;
    endcase
  end

  // Count memory addresses: the item's topic, the loop topic or the clear sweep.
  assign mem_topic = (state_q == lgts_pkg::ST_RDT || state_q == lgts_pkg::ST_CHK) ? t_q : idx_q;
  assign dt_addr  = (state_q == lgts_pkg::ST_CLEAR) ? lgts_pkg::DT_AW'(clr_q) : {doc_q, mem_topic};
  assign wt_addr  = (state_q == lgts_pkg::ST_CLEAR) ? lgts_pkg::WT_AW'(clr_q) : {word_q, mem_topic};
  assign tot_addr = (state_q == lgts_pkg::ST_CLEAR) ? TOPIC_W'(clr_q) : mem_topic;

  lgts_ram #(.WIDTH(COUNT_BITS), .DEPTH(lgts_pkg::DT_DEPTH)) u_dt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (dt_addr),
    .wdata_i (dt_wdata),
    .raddr_i (dt_addr),
    .rdata_o (dt_rdata)
  );

  lgts_ram #(.WIDTH(COUNT_BITS), .DEPTH(lgts_pkg::WT_DEPTH)) u_wt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (wt_addr),
    .wdata_i (wt_wdata),
    .raddr_i (wt_addr),
    .rdata_o (wt_rdata)
  );

  lgts_ram #(.WIDTH(TOTAL_BITS), .DEPTH(lgts_pkg::TOPICS)) u_tot_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (tot_addr),
    .wdata_i (tot_wdata),
    .raddr_i (tot_addr),
    .rdata_o (tot_rdata)
  );

  // Per-topic weights of the current resample.
  lgts_ram #(.WIDTH(lgts_pkg::WGT_W), .DEPTH(lgts_pkg::TOPICS)) u_w_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (idx_q),
    .wdata_i (div_quo),
    .raddr_i (idx_q),
    .rdata_o (w_rdata)
  );

  lgts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Control state, configuration and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lgts_pkg::ST_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
      alpha_q     <= lgts_pkg::ALPHA_RST;
      beta_q      <= lgts_pkg::BETA_RST;
      vocab_q     <= lgts_pkg::VOCAB_RST;
      numt_q      <= lgts_pkg::NUMT_RST;
    end else begin
      state_q <= state_d;
      if (state_q == lgts_pkg::ST_CLEAR) begin
        clr_q <= clr_q + lgts_pkg::CLR_W'(1);
      end
      if (res_valid_q && res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      if (state_q == lgts_pkg::ST_EMIT && emit_ok) begin
        res_valid_q <= 1'b1;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (lgts_pkg::cfg_idx_e'(cfg_i.index))
          lgts_pkg::CFG_ALPHA: alpha_q <= cfg_i.data;
          lgts_pkg::CFG_BETA:  beta_q  <= cfg_i.data;
          lgts_pkg::CFG_VOCAB: vocab_q <= cfg_i.data[lgts_pkg::VOCAB_REG_W-1:0];
          lgts_pkg::CFG_NUMT:  numt_q  <= cfg_i.data[lgts_pkg::NUMT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      lgts_pkg::ST_IDLE: if (tok_xfer) begin
        op_q   <= tok_i.operation;
        doc_q  <= lgts_pkg::DOC_W'(tok_i.doc_index);
        word_q <= lgts_pkg::WORD_W'(tok_i.word_index);
        t_q    <= TOPIC_W'(t_ext);
        draw_q <= tok_i.random_draw;
        k_q    <= lgts_pkg::K_W'(k_ext);
      end
      lgts_pkg::ST_RDT: begin
        vb_q <= lgts_pkg::VB_W'(v_eff) * lgts_pkg::VB_W'(beta_q);
      end
      lgts_pkg::ST_CHK: begin
        err_q <= (op_q == lgts_pkg::OP_RESAMPLE) && cnt_zero;
        sum_q <= '0;
        if (op_q == lgts_pkg::OP_ADD || cnt_zero) begin
          idx_q <= t_q;
        end else begin
          idx_q <= '0;
        end
      end
      lgts_pkg::ST_WLD: begin
        fa_q  <= lgts_pkg::FA_W'(alpha_q) + (lgts_pkg::FA_W'(dt_rdata) << lgts_pkg::FRAC);
        fb_q  <= lgts_pkg::FA_W'(beta_q) + (lgts_pkg::FA_W'(wt_rdata) << lgts_pkg::FRAC);
        den_q <= (lgts_pkg::DEN_W'(tot_rdata) << lgts_pkg::FRAC) + lgts_pkg::DEN_W'(vb_q);
      end
      lgts_pkg::ST_WMA: begin
        prod_q <= lgts_pkg::PROD_W'(fa_q) * lgts_pkg::PROD_W'(fb_q[lgts_pkg::FB_LO-1:0]);
      end
      lgts_pkg::ST_WMB: begin
        prod_q <= prod_q + ((lgts_pkg::PROD_W'(fa_q)
                  * lgts_pkg::PROD_W'(fb_q[lgts_pkg::FA_W-1:lgts_pkg::FB_LO])) << lgts_pkg::FB_LO);
      end
      lgts_pkg::ST_WDW: if (div_done) begin
        sum_q <= sum_q + lgts_pkg::SUM_W'(div_quo);
        if (!last_topic) begin
          idx_q <= idx_q + TOPIC_W'(1);
        end
      end
      lgts_pkg::ST_THR: begin
        thr_q  <= lgts_pkg::THR_W'(draw_q) * lgts_pkg::THR_W'(sum_q);
        runc_q <= '0;
        idx_q  <= '0;
      end
      lgts_pkg::ST_PMUL: begin
        wc_q <= lgts_pkg::WC_W'(w_rdata) * lgts_pkg::WC_W'(lgts_pkg::DRAW_SCALE);
      end
      lgts_pkg::ST_PACC: if (!(hit || last_topic)) begin
        runc_q <= runc_sum;
        idx_q  <= idx_q + TOPIC_W'(1);
      end
      lgts_pkg::ST_EMIT: if (emit_ok) begin
        res_topic_q <= lgts_pkg::TOPIC_FIELD_W'(idx_q);
        res_err_q   <= err_q;
      end
      default: ;
    endcase
  end

  assign tok_i.ready       = (state_q == lgts_pkg::ST_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign res_o.valid       = res_valid_q;
  assign res_o.new_topic   = res_topic_q;
  assign res_o.count_error = res_err_q;

endmodule

FILE: hw/rtl/lgts_checker.sv
module lgts_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               tok_valid_i,
  input logic                               tok_ready_i,
  input logic                               res_valid_i,
  input logic                               res_ready_i,
  input logic [lgts_pkg::TOPIC_FIELD_W-1:0] res_topic_i,
  input logic                               res_err_i
);

  // A result offered and not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_topic_i) && $stable(res_err_i))
    else $error("result payload changed while stalled");

  // Items are handled one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && tok_ready_i |=> !tok_ready_i)
    else $error("second token taken while one is in work");

  // No result can come out in the cycle after a token transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && tok_ready_i |=> !$rose(res_valid_i))
    else $error("result appeared too early");

  // Reset holds the result channel empty and input closed.
  assert property (@(posedge clk_i)
    !rst_ni |-> !res_valid_i && !tok_ready_i)
    else $error("channel active during reset");

endmodule

bind lda_gibbs_topic_sampler lgts_checker u_lgts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .tok_valid_i (tok_i.valid),
  .tok_ready_i (tok_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_topic_i (res_o.new_topic),
  .res_err_i   (res_o.count_error)
);

FILE: tb/sv/lda_gibbs_topic_sampler_chk.sv
// Watches the token, result and register channels of the topic sampler,
// keeps its own copy of the count tables and registers, and compares every
// result transfer against the oldest predicted topic.
module lda_gibbs_topic_sampler_chk (
  input  logic clk_i,
  input  logic rst_ni,
  lgts_tok_if  tok,
  lgts_res_if  res,
  lgts_cfg_if  cfg,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [lgts_pkg::TOPIC_FIELD_W-1:0] topic;
    logic                               err;
  } topic_result_t;

  bit [lgts_pkg::COUNT_BITS-1:0]  doc_cnt  [lgts_pkg::DT_DEPTH];
  bit [lgts_pkg::COUNT_BITS-1:0]  word_cnt [lgts_pkg::WT_DEPTH];
  bit [lgts_pkg::TOTAL_BITS-1:0]  topic_tot[lgts_pkg::TOPICS];
  bit [lgts_pkg::PRIOR_W-1:0]     alpha_r;
  bit [lgts_pkg::PRIOR_W-1:0]     beta_r;
  bit [lgts_pkg::VOCAB_REG_W-1:0] vocab_r;
  bit [lgts_pkg::NUMT_W-1:0]      numt_r;
  topic_result_t                  topic_expq[$];

  function automatic bit [lgts_pkg::COUNT_BITS-1:0] bump_cnt(
      bit [lgts_pkg::COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic bit [lgts_pkg::TOTAL_BITS-1:0] bump_tot(
      bit [lgts_pkg::TOTAL_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Applies one token to the shadow tables and returns the topic it lands on.
  function automatic topic_result_t sample_topic(bit op,
      bit [lgts_pkg::DOC_FIELD_W-1:0] d, bit [lgts_pkg::WORD_FIELD_W-1:0] w,
      bit [lgts_pkg::TOPIC_FIELD_W-1:0] t0, bit [lgts_pkg::DRAW_W-1:0] draw);
    int k;
    int t;
    int di;
    int wi;
    int chosen;
    bit [63:0] vb;
    bit [63:0] den;
    bit [63:0] sum;
    bit [63:0] thr;
    bit [63:0] run;
    bit [69:0] fa;
    bit [69:0] fb;
    bit [69:0] quo;
    bit [31:0] wt[lgts_pkg::TOPICS];
    topic_result_t r;
    k = numt_r;
    if (k < 2) k = 2;
    if (k > lgts_pkg::TOPICS) k = lgts_pkg::TOPICS;
    t = t0;
    if (t >= k) t = k - 1;
    di = (d % lgts_pkg::DOCS) * lgts_pkg::TOPICS;
    wi = (w % lgts_pkg::VOCAB) * lgts_pkg::TOPICS;
    r.topic = t;
    r.err = 1'b0;
    if (op == lgts_pkg::OP_ADD) begin
      doc_cnt[di+t] = bump_cnt(doc_cnt[di+t]);
      word_cnt[wi+t] = bump_cnt(word_cnt[wi+t]);
      topic_tot[t] = bump_tot(topic_tot[t]);
      return r;
    end
    if (doc_cnt[di+t] == 0 || word_cnt[wi+t] == 0 || topic_tot[t] == 0) begin
      r.err = 1'b1;
      return r;
    end
    doc_cnt[di+t]--;
    word_cnt[wi+t]--;
    topic_tot[t]--;
    // Dense weight pass over the topics in use.
    vb = ((vocab_r == 0) ? 64'd1 : 64'(vocab_r)) * 64'(beta_r);
    sum = 0;
    for (int i = 0; i < k; i++) begin
      fa = 70'(alpha_r) + (70'(doc_cnt[di+i]) << 16);
      fb = 70'(beta_r) + (70'(word_cnt[wi+i]) << 16);
      den = (64'(topic_tot[i]) << 16) + vb;
      if (den == 0) begin
        wt[i] = 0;
      end else begin
        quo = (fa * fb) / 70'(den);
        wt[i] = (quo > 70'h0FFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
      end
      sum += wt[i];
    end
    thr = 64'(draw) * sum / 64'd100000;
    chosen = k - 1;
    run = 0;
    for (int i = 0; i < k; i++) begin
      run += wt[i];
      if (run > thr) begin
        chosen = i;
        break;
      end
    end
    doc_cnt[di+chosen] = bump_cnt(doc_cnt[di+chosen]);
    word_cnt[wi+chosen] = bump_cnt(word_cnt[wi+chosen]);
    topic_tot[chosen] = bump_tot(topic_tot[chosen]);
    r.topic = chosen;
    return r;
  endfunction

  // Register writes, result comparison, then prediction for new tokens.
  always @(posedge clk_i or negedge rst_ni) begin
    topic_result_t exp_r;
    if (!rst_ni) begin
      foreach (doc_cnt[i]) doc_cnt[i] = '0;
      foreach (word_cnt[i]) word_cnt[i] = '0;
      foreach (topic_tot[i]) topic_tot[i] = '0;
      alpha_r = lgts_pkg::ALPHA_RST;
      beta_r = lgts_pkg::BETA_RST;
      vocab_r = lgts_pkg::VOCAB_RST;
      numt_r = lgts_pkg::NUMT_RST;
      topic_expq.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (lgts_pkg::cfg_idx_e'(cfg.index))
          lgts_pkg::CFG_ALPHA: alpha_r = cfg.data;
          lgts_pkg::CFG_BETA:  beta_r = cfg.data;
          lgts_pkg::CFG_VOCAB: vocab_r = cfg.data[lgts_pkg::VOCAB_REG_W-1:0];
          lgts_pkg::CFG_NUMT:  numt_r = cfg.data[lgts_pkg::NUMT_W-1:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (topic_expq.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected result topic=%0d err=%0b", $time,
                     res.new_topic, res.count_error);
        end else begin
          exp_r = topic_expq.pop_front();
          if (res.new_topic !== exp_r.topic || res.count_error !== exp_r.err) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch topic exp=%0d got=%0d, err exp=%0b got=%0b",
                       $time, exp_r.topic, res.new_topic, exp_r.err, res.count_error);
          end
        end
      end
      if (tok.valid && tok.ready) begin
        exp_r = sample_topic(tok.operation, tok.doc_index, tok.word_index,
                             tok.old_topic, tok.random_draw);
        topic_expq = {topic_expq, exp_r};
      end
      pending_o = topic_expq.size();
    end
  end

endmodule

FILE: tb/sv/lda_gibbs_topic_sampler_tb.sv
module lda_gibbs_topic_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   take_idle_pct;
  int   hold_len;

  // Token pool: documents and words reused so counts build up.
  bit [lgts_pkg::DOC_FIELD_W-1:0]   doc_pool[16];
  bit [lgts_pkg::WORD_FIELD_W-1:0]  word_pool[16];
  bit [lgts_pkg::DOC_FIELD_W-1:0]   tk_doc[$];
  bit [lgts_pkg::WORD_FIELD_W-1:0]  tk_word[$];
  bit [lgts_pkg::TOPIC_FIELD_W-1:0] tk_topic[$];
  bit                               tk_busy[$];
  int                               owner_q[$];

  lgts_tok_if tok();
  lgts_res_if res();
  lgts_cfg_if cfg();

  lda_gibbs_topic_sampler uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (tok),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  lda_gibbs_topic_sampler_chk chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok          (tok),
    .res          (res),
    .cfg          (cfg),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        res.ready <= 1'b0;
        hold_len--;
      end else begin
        res.ready <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  // Track where each pooled token now sits, taken from its result.
  always @(posedge clk_i) begin
    int id;
    if (rst_ni && res.valid && res.ready && owner_q.size() > 0) begin
      id = owner_q.pop_front();
      if (id >= 0) begin
        tk_topic[id] = res.new_topic;
        tk_busy[id] = 1'b0;
      end
    end
  end

  task automatic send_tok(bit op, bit [lgts_pkg::DOC_FIELD_W-1:0] d,
                          bit [lgts_pkg::WORD_FIELD_W-1:0] w,
                          bit [lgts_pkg::TOPIC_FIELD_W-1:0] t,
                          bit [lgts_pkg::DRAW_W-1:0] dr, int id);
    tok.valid <= 1'b1;
    tok.operation <= op;
    tok.doc_index <= d;
    tok.word_index <= w;
    tok.old_topic <= t;
    tok.random_draw <= dr;
    @(posedge clk_i);
    while (!tok.ready) @(posedge clk_i);
    owner_q = {owner_q, id};
    if (id >= 0) tk_busy[id] = 1'b1;
    if ($urandom_range(99) < send_idle_pct) begin
      tok.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every predicted result has arrived.
  task automatic drain();
    tok.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic apply_config(bit [23:0] a, bit [23:0] b, bit [23:0] v, bit [23:0] k);
    bit [23:0] vals[4];
    vals = '{a, b, v, k};
    for (int i = 0; i < 4; i++) begin
      cfg.valid <= 1'b1;
      cfg.index <= lgts_pkg::cfg_idx_e'(i);
      cfg.data <= vals[i];
      @(posedge clk_i);
      while (!cfg.ready) @(posedge clk_i);
    end
    cfg.valid <= 1'b0;
  endtask

  // One random token: mostly adds and resamples of known tokens, some noise.
  task automatic random_tok();
    int r;
    int id;
    r = $urandom_range(99);
    id = -1;
    if (r < 50 && tk_doc.size() > 0) begin
      repeat (4) begin
        id = $urandom_range(tk_doc.size() - 1);
        if (!tk_busy[id]) break;
      end
      if (tk_busy[id]) id = -1;
    end
    if (id >= 0) begin
      send_tok(lgts_pkg::OP_RESAMPLE, tk_doc[id], tk_word[id], tk_topic[id],
               ($urandom_range(19) == 0) ? 17'($urandom_range(131071))
                                         : 17'($urandom_range(99999)), id);
    end else if (r < 88) begin
      tk_doc = {tk_doc, doc_pool[$urandom_range(15)]};
      tk_word = {tk_word, word_pool[$urandom_range(15)]};
      tk_topic = {tk_topic, lgts_pkg::TOPIC_FIELD_W'($urandom_range(63))};
      tk_busy = {tk_busy, 1'b0};
      id = tk_doc.size() - 1;
      send_tok(lgts_pkg::OP_ADD, tk_doc[id], tk_word[id], tk_topic[id],
               $urandom_range(131071), id);
    end else begin
      send_tok($urandom_range(1), $urandom_range(1023), $urandom_range(4095),
               $urandom_range(63), $urandom_range(131071), -1);
    end
  endtask

  task automatic run_phase(bit [23:0] a, bit [23:0] b, bit [23:0] v, bit [23:0] k, int n);
    drain();
    apply_config(a, b, v, k);
    repeat (n) random_tok();
  endtask

  initial begin
    #100ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    hold_len = 0;
    send_idle_pct = 10;
    take_idle_pct = 53;
    tok.valid = 1'b0;
    tok.operation = lgts_pkg::OP_ADD;
    tok.doc_index = '0;
    tok.word_index = '0;
    tok.old_topic = '0;
    tok.random_draw = '0;
    cfg.valid = 1'b0;
    cfg.index = lgts_pkg::CFG_ALPHA;
    cfg.data = '0;
    foreach (doc_pool[i]) doc_pool[i] = $urandom_range(1023);
    foreach (word_pool[i]) word_pool[i] = $urandom_range(4095);
    doc_pool[0] = '1;
    word_pool[0] = '1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty resample, field extremes, draw at both ends and beyond.
    send_tok(lgts_pkg::OP_RESAMPLE, 10'd0, 12'd0, 6'd0, 17'd0, -1);
    send_tok(lgts_pkg::OP_ADD, 10'd1023, 12'd4095, 6'd63, 17'd0, -1);
    send_tok(lgts_pkg::OP_ADD, 10'd0, 12'd0, 6'd0, 17'd99999, -1);
    send_tok(lgts_pkg::OP_ADD, 10'd1023, 12'd4095, 6'd63, 17'd131071, -1);
    send_tok(lgts_pkg::OP_RESAMPLE, 10'd1023, 12'd4095, 6'd63, 17'd0, -1);
    send_tok(lgts_pkg::OP_ADD, 10'd1023, 12'd4095, 6'd63, 17'd0, -1);
    send_tok(lgts_pkg::OP_RESAMPLE, 10'd1023, 12'd4095, 6'd63, 17'd99999, -1);
    send_tok(lgts_pkg::OP_ADD, 10'd0, 12'd4095, 6'd0, 17'd0, -1);
    send_tok(lgts_pkg::OP_RESAMPLE, 10'd0, 12'd0, 6'd0, 17'd131071, -1);
    send_tok(lgts_pkg::OP_RESAMPLE, 10'd0, 12'd4095, 6'd0, 17'd50000, -1);
    send_tok(lgts_pkg::OP_RESAMPLE, 10'd512, 12'd2048, 6'd32, 17'd65536, -1);
    repeat (80) random_tok();

    // Zero priors give zero denominators for empty topics (a zero vocabulary counts as one); K clamps up.
    run_phase(24'd0, 24'd0, 24'd0, 24'd1, 150);
    // Largest priors with a full vocabulary; K clamps down to the table size.
    run_phase(24'hFF_FFFF, 24'hFF_FFFF, 24'd4096, 24'd127, 40);

    send_idle_pct = 53;
    take_idle_pct = 10;
    run_phase(24'd6554, 24'd655, 24'd100, 24'd8, 330);

    // No idling; one long receiver hold-off fills the block.
    send_idle_pct = 0;
    take_idle_pct = 0;
    drain();
    hold_len = 3000;
    run_phase($urandom_range(24'hFF_FFFF), $urandom_range(24'hFF_FFFF),
              $urandom_range(1, 4096), 24'd13, 300);
    run_phase(24'd65536, 24'd1, 24'd1, 24'd2, 200);
    drain();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
